@@ rtl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, tables and GF(2^8) helpers for the AES-128 CBC engine.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int BLOCK_W   = 128;
    localparam int HALF_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int ROUND_W   = 4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic [1:0] OP_LOAD_IV = 2'd0;
    localparam logic [1:0] OP_ENCRYPT = 2'd1;
    localparam logic [1:0] OP_DECRYPT = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] RCON_LAST  = 8'h36;

    typedef enum logic [2:0] {
        ST_KLOAD,
        ST_KEXP,
        ST_IDLE,
        ST_ENC,
        ST_DEC
    } aes_state_t;

    typedef struct packed {
        logic load_iv;
        logic load_enc;
        logic load_dec;
        logic key_load;
        logic key_step;
        logic round_en;
        logic round_last;
        logic dec_mode;
    } aes_cmd_t;

    typedef struct packed {
        logic out_valid;
    } aes_status_t;

    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_TBL = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TBL[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_TBL[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Inverse of xtime, used to walk the round constant backwards.
    function automatic logic [7:0] xtime_inv(input logic [7:0] a);
        return a[0] ? ({1'b1, (a[7:1] ^ 7'h0d)}) : {1'b0, a[7:1]};
    endfunction

    function automatic logic [31:0] sub_rot_word(input logic [31:0] w);
        return {sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = s[127 - 8 * (r + 4 * c) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8 * i -: 8] = sbox(s[127 - 8 * i -: 8]);
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
        logic [127:0] t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8 * i -: 8] = inv_sbox(s[127 - 8 * i -: 8]);
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] a);
        logic [7:0] a0, a1, a2, a3;
        a0 = a[31:24];
        a1 = a[23:16];
        a2 = a[15:8];
        a3 = a[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
        logic [7:0] a0, a1, a2, a3;
        a0 = a[31:24];
        a1 = a[23:16];
        a2 = a[15:8];
        a3 = a[7:0];
        return {mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3),
                mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3),
                mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3),
                mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3)};
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        return {mix_col(s[127:96]), mix_col(s[95:64]), mix_col(s[63:32]), mix_col(s[31:0])};
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
                inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
    endfunction

    // Next round key from the current one.
    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] n0, n1, n2, n3;
        n0 = k[127:96] ^ sub_rot_word(k[31:0]) ^ {rc, 24'h0};
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // Previous round key from the current one; rc is the constant of the current round.
    function automatic logic [127:0] key_back(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] p0, p1, p2, p3;
        p3 = k[31:0] ^ k[63:32];
        p2 = k[63:32] ^ k[95:64];
        p1 = k[95:64] ^ k[127:96];
        p0 = k[127:96] ^ sub_rot_word(p3) ^ {rc, 24'h0};
        return {p0, p1, p2, p3};
    endfunction

endpackage

`default_nettype wire

@@ rtl/aes_ctrl.sv @@
// ----------------------------------------------------------------------------
// aes_ctrl
// Sequencer for key expansion, block rounds and the item handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ctrl
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    output logic             cfg_ready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic        out_ready,
    input  wire aes_status_t status,
    output aes_cmd_t         cmd
);

    aes_state_t         state_reg, state_next;
    logic [ROUND_W-1:0] cnt_reg, cnt_next;
    logic               out_free;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_KLOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign out_free = !status.out_valid || out_ready;

    // Key writes are held off while a block is in the round unit.
    assign cfg_ready = (state_reg != ST_ENC) && (state_reg != ST_DEC);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_KLOAD: begin
                cmd.key_load = 1'b1;
                cnt_next     = 4'd1;
                state_next   = ST_KEXP;
            end
            ST_KEXP: begin
                cmd.key_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // A key write in the same cycle goes first; the item waits.
                in_ready = !cfg_write;
                if (in_valid && !cfg_write) begin
                    cnt_next = 4'd1;
                    unique case (operation)
                        OP_LOAD_IV: cmd.load_iv = 1'b1;
                        OP_ENCRYPT: begin
                            cmd.load_enc = 1'b1;
                            state_next   = ST_ENC;
                        end
                        OP_DECRYPT: begin
                            cmd.load_dec = 1'b1;
                            state_next   = ST_DEC;
                        end
                        OP_UNUSED: ;
                    endcase
                end
            end
            ST_ENC, ST_DEC: begin
                cmd.dec_mode   = (state_reg == ST_DEC);
                cmd.round_last = (cnt_reg == LAST_ROUND);
                // The last round only runs once the output register can take the result.
                if (!cmd.round_last || out_free) begin
                    cmd.round_en = 1'b1;
                    cnt_next     = cnt_reg + 4'd1;
                    if (cmd.round_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_KLOAD;
        endcase
        // A key write restarts expansion of the decryption key.
        if (cfg_write) begin
            state_next = ST_KLOAD;
            cnt_next   = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/aes_datapath.sv @@
// ----------------------------------------------------------------------------
// aes_datapath
// Key, chaining value and output registers; one AES round per cycle when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_datapath
    import aes_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HALF_W-1:0]    cfg_data,
    input  wire aes_cmd_t             cmd,
    input  wire logic [HALF_W-1:0]    data_high,
    input  wire logic [HALF_W-1:0]    data_low,
    input  wire logic                 last_block,
    input  wire logic                 out_ready,
    output aes_status_t               status,
    output logic [HALF_W-1:0]         result_high,
    output logic [HALF_W-1:0]         result_low,
    output logic                      last_out
);

    logic [HALF_W-1:0]  key_high_reg, key_low_reg;
    logic [BLOCK_W-1:0] cv_reg;
    logic [BLOCK_W-1:0] st_reg;
    logic [BLOCK_W-1:0] rk_reg;
    logic [BLOCK_W-1:0] rk10_reg;
    logic [BLOCK_W-1:0] ct_reg;
    logic [BLOCK_W-1:0] res_reg;
    logic [7:0]         rc_reg;
    logic               last_reg, last_out_reg;
    logic               out_valid_reg;

    logic [BLOCK_W-1:0] key_w, data_w;
    logic [BLOCK_W-1:0] rk_fwd, rk_back;
    logic [BLOCK_W-1:0] enc_sr, enc_next, dec_ak, dec_next;

    assign key_w  = {key_high_reg, key_low_reg};
    assign data_w = {data_high, data_low};
    assign rk_fwd  = key_fwd(rk_reg, rc_reg);
    assign rk_back = key_back(rk_reg, rc_reg);

    always_comb begin
        enc_sr   = shift_rows(sub_bytes(st_reg));
        enc_next = (cmd.round_last ? enc_sr : mix_columns(enc_sr)) ^ rk_fwd;
        dec_ak   = inv_sub_bytes(inv_shift_rows(st_reg)) ^ rk_back;
        dec_next = cmd.round_last ? dec_ak : inv_mix_columns(dec_ak);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            cv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                endcase
            end
            if (cmd.load_iv) begin
                cv_reg <= data_w;
            end else if (cmd.round_en && cmd.round_last) begin
                cv_reg <= cmd.dec_mode ? ct_reg : enc_next;
            end
            if (cmd.round_en && cmd.round_last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.key_load) begin
            rk_reg <= key_w;
            rc_reg <= RCON_FIRST;
        end
        if (cmd.key_step) begin
            rk_reg   <= rk_fwd;
            rk10_reg <= rk_fwd;
            rc_reg   <= xtime(rc_reg);
        end
        if (cmd.load_enc) begin
            st_reg   <= data_w ^ cv_reg ^ key_w;
            rk_reg   <= key_w;
            rc_reg   <= RCON_FIRST;
            last_reg <= last_block;
        end
        if (cmd.load_dec) begin
            st_reg   <= data_w ^ rk10_reg;
            rk_reg   <= rk10_reg;
            rc_reg   <= RCON_LAST;
            ct_reg   <= data_w;
            last_reg <= last_block;
        end
        if (cmd.round_en) begin
            if (cmd.dec_mode) begin
                st_reg <= dec_next;
                rk_reg <= rk_back;
                rc_reg <= xtime_inv(rc_reg);
            end else begin
                st_reg <= enc_next;
                rk_reg <= rk_fwd;
                rc_reg <= xtime(rc_reg);
            end
            if (cmd.round_last) begin
                res_reg      <= cmd.dec_mode ? (dec_next ^ cv_reg) : enc_next;
                last_out_reg <= last_reg;
            end
        end
    end

    assign status.out_valid = out_valid_reg;
    assign result_high      = res_reg[127:64];
    assign result_low       = res_reg[63:0];
    assign last_out         = last_out_reg;

endmodule

`default_nettype wire

@@ rtl/aes128_cbc_engine.sv @@
// ----------------------------------------------------------------------------
// aes128_cbc_engine
// AES-128 block cipher in cipher block chaining mode with a register key.
// ----------------------------------------------------------------------------
// An item with operation load-IV sets the chaining value and returns nothing;
// encrypt and decrypt items each return one block on the output channel, with
// last_out copying last_block. Each block is loaded and then runs ten rounds
// of the single shared round unit, which also steps the round key on the fly.
// The last round waits while the previous result is still held in the output
// register and not taken. The next item is taken only after the current one
// has left the round unit, since each block chains on the one before. After
// reset and after every key write the engine derives the final round key,
// which decryption runs backwards from; no item is accepted in that time.
// Configuration writes are accepted except while a block is in the round
// unit, and a write offered in the same cycle as an item goes first while
// the item waits.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_cbc_engine
    import aes_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HALF_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic [HALF_W-1:0]    data_high,
    input  wire logic [HALF_W-1:0]    data_low,
    input  wire logic                 last_block,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [HALF_W-1:0]         result_high,
    output logic [HALF_W-1:0]         result_low,
    output logic                      last_out
);

    aes_cmd_t    cmd;
    aes_status_t status;
    logic        cfg_write;

    // Key writes restart key preparation.
    assign cfg_write = cfg_valid && cfg_ready;

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_ready (cfg_ready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    aes_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .data_high   (data_high),
        .data_low    (data_low),
        .last_block  (last_block),
        .out_ready   (out_ready),
        .status      (status),
        .result_high (result_high),
        .result_low  (result_low),
        .last_out    (last_out)
    );

    assign out_valid = status.out_valid;

endmodule

`default_nettype wire
